/* rtl/gfc_pkg.sv */
`timescale 1ns / 1ps

package gfc_pkg;

  // field widths, fixed by the interface
  localparam int KIND_W = 3;
  localparam int SRC_W = 22;
  localparam int TEMP_W = 8;
  localparam int DUTY_W = 7;
  localparam int FAN_W = 3;
  localparam int MC_W = 4;

  // slot table size: default and the widest slot index supported
  localparam int MAX_SLOTS_DEF = 8;
  localparam int SLOT_IDX_W = 6;

  // remainder unit takes two source bits per cycle
  localparam int MOD_STEPS = SRC_W / 2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [KIND_W-1:0] KIND_NORMAL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DETACH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ATTACH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_URGENT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK = 3'd4;

  localparam logic [MC_W-1:0] MC_RESET = 4'd8;
  localparam logic [MC_W-1:0] CNT_SAT = 4'd15;

  localparam logic [TEMP_W-1:0] TEMP_LOW = 8'd20;
  localparam logic [TEMP_W-1:0] TEMP_HIGH = 8'd70;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  // classified message handed from the front to the back
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_IDX_W-1:0] slot;
    logic [TEMP_W-1:0] temp;
  } cmd_t;

  // fan curve: 0 up to 20, 100 from 70, twice the excess over 20 between
  function automatic logic [DUTY_W-1:0] duty_of(input logic [TEMP_W-1:0] t);
    logic [TEMP_W-1:0] d;
    d = t - TEMP_LOW;
    if (t <= TEMP_LOW) begin
      return '0;
    end else if (t >= TEMP_HIGH) begin
      return DUTY_FULL;
    end else begin
      return {d[DUTY_W-2:0], 1'b0};
    end
  endfunction

endpackage

/* rtl/group_fan_curve_controller_unit.sv */
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// in        to block   in_valid / in_ready     kind, source_id, temperature
// out       from block out_valid / out_ready   fan_slot, duty_percent, group_max_temp, last
// config    to block   psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// a message passes the front in order: accept, the remainder unit (two source_id bits
// a cycle against the clamped module count), then the hand-off to the queue; a tick
// skips the remainder unit
// the back takes a message while idle and the result register is free; a tick scans
// the slot table one slot a cycle through the temperature memory read port, then walks
// slot 0 up to the last attached slot one slot a cycle, giving a result for each
// attached fan as the result register frees up
// reset is synchronous and clears the table flags, counts, queue and handshakes
// a stalled output holds the back; the front keeps accepting until the queue fills

module group_fan_curve_controller_unit import gfc_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // message requests
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [SRC_W-1:0]  source_id,
  input  logic [TEMP_W-1:0] temperature,
  // fan settings
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FAN_W-1:0]  fan_slot,
  output logic [DUTY_W-1:0] duty_percent,
  output logic [TEMP_W-1:0] group_max_temp,
  output logic              last,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // register index as seen in the word address bit
  localparam logic REG_MODULE_COUNT = 1'b0;

  logic [MC_W-1:0] module_count;
  logic [MC_W-1:0] eff_count;
  logic            cfg_write;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MODULE_COUNT) ? 32'(module_count) : '0;

  // register keeps the bits written; zero acts as one, large values clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      module_count <= MC_RESET;
    end else if (cfg_write && paddr[2] == REG_MODULE_COUNT) begin
      module_count <= pwdata[MC_W-1:0];
    end
  end

  always_comb begin
    if (module_count == '0) begin
      eff_count = 4'd1;
    end else if (int'(module_count) > MAX_SLOTS) begin
      eff_count = MC_W'(MAX_SLOTS);
    end else begin
      eff_count = module_count;
    end
  end

  // front: takes requests, drops unknown kinds, reduces source_id to a slot
  gfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .source_id   (source_id),
    .temperature (temperature),
    .eff_count   (eff_count),
    .push        (push),
    .push_cmd    (push_cmd),
    .full        (q_full)
  );

  // two-entry queue decouples slot selection from table work
  gfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  // back: slot table, tick scan and fan sweep, result register
  gfc_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .eff_count      (eff_count),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .fan_slot       (fan_slot),
    .duty_percent   (duty_percent),
    .group_max_temp (group_max_temp),
    .last           (last)
  );

endmodule

/* rtl/gfc_front.sv */
`timescale 1ns / 1ps

module gfc_front import gfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [SRC_W-1:0]  source_id,
  input  logic [TEMP_W-1:0] temperature,
  input  logic [MC_W-1:0]   eff_count,
  output logic              push,
  output cmd_t              push_cmd,
  input  logic              full
);

  localparam int STEP_W = $clog2(MOD_STEPS + 1);

  logic              busy;
  logic              dividing;
  logic [KIND_W-1:0] f_kind;
  logic [TEMP_W-1:0] f_temp;
  logic [SRC_W-1:0]  src_sh;
  logic [MC_W-1:0]   rem;
  logic [MC_W-1:0]   rem_step;
  logic [STEP_W-1:0] steps;

  // one restoring remainder step, remainder stays below the divisor
  function automatic logic [MC_W-1:0] mod_bit(input logic [MC_W-1:0] r, input logic b,
                                              input logic [MC_W-1:0] d);
    logic [MC_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[MC_W-1:0];
  endfunction

  assign rem_step = mod_bit(mod_bit(rem, src_sh[SRC_W-1], eff_count), src_sh[SRC_W-2],
                            eff_count);

  assign in_ready = !busy;
  assign push = busy && !dividing && !full;
  assign push_cmd = '{kind: f_kind, slot: SLOT_IDX_W'(rem), temp: f_temp};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dividing <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        f_kind <= kind;
        f_temp <= temperature;
        src_sh <= source_id;
        rem <= '0;
        steps <= STEP_W'(MOD_STEPS);
        // unknown kinds are dropped here
        busy <= (kind inside {KIND_NORMAL, KIND_DETACH, KIND_ATTACH, KIND_URGENT,
                              KIND_TICK});
        dividing <= (kind inside {KIND_NORMAL, KIND_DETACH, KIND_ATTACH, KIND_URGENT});
      end else if (dividing) begin
        rem <= rem_step;
        src_sh <= src_sh << 2;
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          dividing <= 1'b0;
        end
      end else if (push) begin
        busy <= 1'b0;
      end
    end
  end

  a_div_only_busy: assert property (@(posedge clk) disable iff (rst)
    dividing |-> busy && !push)
    else $error("remainder unit running outside a held request");

endmodule

/* rtl/gfc_queue.sv */
`timescale 1ns / 1ps

module gfc_queue import gfc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("queue read while empty");

endmodule

/* rtl/gfc_back.sv */
`timescale 1ns / 1ps

module gfc_back import gfc_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [MC_W-1:0]   eff_count,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FAN_W-1:0]  fan_slot,
  output logic [DUTY_W-1:0] duty_percent,
  output logic [TEMP_W-1:0] group_max_temp,
  output logic              last
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCAN_W = $clog2(MAX_SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state;
  logic [MAX_SLOTS-1:0] attached;
  logic [MAX_SLOTS-1:0] temp_valid;
  logic [MC_W-1:0]      attached_count;
  logic [TEMP_W-1:0]    max_temperature;

  logic [TEMP_W-1:0] temp_mem [MAX_SLOTS];
  logic              mem_we;
  logic [SLOT_W-1:0] mem_raddr;
  logic [TEMP_W-1:0] mem_rdata;

  logic [SCAN_W-1:0] scan_idx;
  logic              scan_more;
  logic              rd_live;
  logic [SLOT_W-1:0] rd_slot;
  logic [TEMP_W-1:0] rd_temp;
  logic              found;
  logic [SLOT_W-1:0] last_slot;
  logic [SLOT_W-1:0] emit_slot;
  logic [SLOT_W-1:0] cmd_slot;

  logic              out_free;
  logic              out_load;
  logic [SLOT_W-1:0] load_slot;
  logic [DUTY_W-1:0] load_duty;
  logic [TEMP_W-1:0] load_tmax;
  logic              load_last;

  assign out_free = !out_valid || out_ready;
  assign cmd_slot = q_cmd.slot[SLOT_W-1:0];
  assign q_pop = (state == ST_IDLE) && q_valid && out_free;
  assign scan_more = (state == ST_SCAN) && (scan_idx < SCAN_W'(eff_count));
  assign mem_raddr = scan_idx[SLOT_W-1:0];
  assign mem_we = q_pop && (q_cmd.kind == KIND_NORMAL || q_cmd.kind == KIND_URGENT);
  // a slot never written since reset or last cleared by detach reads zero
  assign rd_temp = temp_valid[rd_slot] ? mem_rdata : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      temp_mem[cmd_slot] <= q_cmd.temp;
    end
    mem_rdata <= temp_mem[mem_raddr];
  end

  always_comb begin
    out_load = 1'b0;
    load_slot = emit_slot;
    load_duty = duty_of(max_temperature);
    load_tmax = max_temperature;
    load_last = (emit_slot == last_slot);
    if (q_pop && q_cmd.kind == KIND_URGENT) begin
      out_load = 1'b1;
      load_slot = cmd_slot;
      load_duty = duty_of(q_cmd.temp);
      load_tmax = q_cmd.temp;
      load_last = 1'b1;
    end else if (state == ST_EMIT && attached[emit_slot] && out_free) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fan_slot <= FAN_W'(load_slot);
      duty_percent <= load_duty;
      group_max_temp <= load_tmax;
      last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      attached <= '0;
      temp_valid <= '0;
      attached_count <= '0;
      max_temperature <= '0;
      out_valid <= 1'b0;
      scan_idx <= '0;
      rd_live <= 1'b0;
      rd_slot <= '0;
      found <= 1'b0;
      last_slot <= '0;
      emit_slot <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_cmd.kind)
              KIND_NORMAL, KIND_ATTACH, KIND_URGENT: begin
                if (!attached[cmd_slot]) begin
                  attached[cmd_slot] <= 1'b1;
                  if (attached_count != CNT_SAT) begin
                    attached_count <= attached_count + 1'b1;
                  end
                end
                if (q_cmd.kind != KIND_ATTACH) begin
                  temp_valid[cmd_slot] <= 1'b1;
                end
              end
              KIND_DETACH: begin
                if (attached[cmd_slot]) begin
                  attached[cmd_slot] <= 1'b0;
                  if (attached_count != '0) begin
                    attached_count <= attached_count - 1'b1;
                  end
                end
                temp_valid[cmd_slot] <= 1'b0;
              end
              KIND_TICK: begin
                if (attached_count != '0) begin
                  state <= ST_SCAN;
                  scan_idx <= '0;
                  rd_live <= 1'b0;
                  found <= 1'b0;
                  max_temperature <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          // reads issue one slot a cycle, data is checked in the next cycle
          rd_live <= scan_more;
          rd_slot <= scan_idx[SLOT_W-1:0];
          if (scan_more) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (rd_live && attached[rd_slot]) begin
            found <= 1'b1;
            last_slot <= rd_slot;
            if (rd_temp > max_temperature) begin
              max_temperature <= rd_temp;
            end
          end
          if (!scan_more && !rd_live) begin
            state <= found ? ST_EMIT : ST_IDLE;
            emit_slot <= '0;
          end
        end
        ST_EMIT: begin
          if (attached[emit_slot]) begin
            if (out_free) begin
              if (emit_slot == last_slot) begin
                state <= ST_IDLE;
              end else begin
                emit_slot <= emit_slot + 1'b1;
              end
            end
          end else begin
            emit_slot <= emit_slot + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_emit_ends_attached: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> attached[last_slot])
    else $error("fan sweep without an attached final slot");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result register overwritten before it was taken");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import gfc_pkg::*;

  // register map
  localparam logic [2:0] REG_MODULE_COUNT = 3'd0;

  // kinds the block ignores
  localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_LAST = 3'd7;

  localparam int SLOT_CAP = MAX_SLOTS_DEF;
  localparam int IDLE_PCT = 31;
  // time for the front, a full scan and a burst of results, with margin
  localparam int QUIET_CYCLES = 48;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_REQUESTS = 12;

  // one fan setting as seen on the result channel
  typedef struct packed {
    logic [FAN_W-1:0]  fan;
    logic [DUTY_W-1:0] duty;
    logic [TEMP_W-1:0] gmax;
    logic              last;
  } fan_setting_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind = '0;
  logic [SRC_W-1:0]  source_id = '0;
  logic [TEMP_W-1:0] temperature = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [FAN_W-1:0]  fan_slot;
  logic [DUTY_W-1:0] duty_percent;
  logic [TEMP_W-1:0] group_max_temp;
  logic              last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // mirror of the slot table and the count register
  bit               fan_attached [SLOT_CAP];
  logic [TEMP_W-1:0] fan_temp [SLOT_CAP];
  int unsigned      attached_total;
  logic [MC_W-1:0]  module_count_mirror;

  // fan settings still owed by the block, oldest first
  fan_setting_t pending_settings[$];

  // run bookkeeping
  int  fail_count = 0;
  int  requests_sent = 0;
  int  urgent_sent = 0;
  int  ticks_sent = 0;
  int  settings_checked = 0;
  int  count_writes = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;          // no idling on either side while set
  int  hold_req = 0;         // bumped by a test to ask for a receiver hold-off
  int  hold_ack = 0;
  int  hold_left = 0;

  group_fan_curve_controller_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .source_id      (source_id),
    .temperature    (temperature),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .fan_slot       (fan_slot),
    .duty_percent   (duty_percent),
    .group_max_temp (group_max_temp),
    .last           (last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d settings still owed", $time,
             cycle_count, pending_settings.size());
    $display("CHECK FAILED");
    $finish;
  end

  // fan curve: flat 0 up to 20 degrees, full from 70, two percent a degree between
  function automatic logic [DUTY_W-1:0] curve_duty(input logic [TEMP_W-1:0] t);
    int excess;
    excess = int'(t) - int'(TEMP_LOW);
    if (t <= TEMP_LOW) begin
      return '0;
    end else if (t >= TEMP_HIGH) begin
      return DUTY_FULL;
    end
    return DUTY_W'(excess * 2);
  endfunction

  // advance the mirrored table by one accepted request and queue its fan settings
  task automatic predict_request(input logic [KIND_W-1:0] k, input logic [SRC_W-1:0] src,
                                 input logic [TEMP_W-1:0] t);
    int span;
    int slot;
    int top_slot;
    logic [TEMP_W-1:0] hottest;
    fan_setting_t s;
    // out-of-range counts clamp to 1 .. SLOT_CAP
    span = module_count_mirror;
    if (span == 0) begin
      span = 1;
    end
    if (span > SLOT_CAP) begin
      span = SLOT_CAP;
    end
    slot = src % span;
    // normal, attach and urgent all attach; a second attach changes nothing
    if (k == KIND_NORMAL || k == KIND_ATTACH || k == KIND_URGENT) begin
      if (!fan_attached[slot]) begin
        fan_attached[slot] = 1'b1;
        if (attached_total < CNT_SAT) begin
          attached_total++;
        end
      end
    end
    case (k)
      KIND_NORMAL: begin
        fan_temp[slot] = t;
      end
      KIND_DETACH: begin
        // only an attached slot lowers the count; temperature is cleared anyway
        if (fan_attached[slot]) begin
          fan_attached[slot] = 1'b0;
          if (attached_total > 0) begin
            attached_total--;
          end
        end
        fan_temp[slot] = '0;
      end
      KIND_URGENT: begin
        // the module's own reading sets its fan right away
        fan_temp[slot] = t;
        s.fan = FAN_W'(slot);
        s.duty = curve_duty(t);
        s.gmax = t;
        s.last = 1'b1;
        pending_settings.push_back(s);
      end
      KIND_TICK: begin
        // nothing at all while the count says no module is attached
        if (attached_total != 0) begin
          hottest = '0;
          top_slot = -1;
          for (int i = 0; i < span; i++) begin
            if (fan_attached[i]) begin
              if (fan_temp[i] > hottest) begin
                hottest = fan_temp[i];
              end
              top_slot = i;
            end
          end
          // one setting per attached fan below the count, ascending
          for (int i = 0; i < span; i++) begin
            if (fan_attached[i]) begin
              s.fan = FAN_W'(i);
              s.duty = curve_duty(hottest);
              s.gmax = hottest;
              s.last = (i == top_slot);
              pending_settings.push_back(s);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // offer one request, with random idle cycles ahead of it, and wait for acceptance;
  // in_valid is left high so a back-to-back request needs no second assignment
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [SRC_W-1:0] src,
                              input logic [TEMP_W-1:0] t);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    kind <= k;
    source_id <= src;
    temperature <= t;
    do @(posedge clk); while (!in_ready);
    predict_request(k, src, t);
    requests_sent++;
    if (k == KIND_URGENT) begin
      urgent_sent++;
    end
    if (k == KIND_TICK) begin
      ticks_sent++;
    end
  endtask

  // stop offering and wait for every owed fan setting
  task automatic wait_for_settings();
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // idle block: nothing owed and time for silent requests to retire
  task automatic wait_until_quiet();
    wait_for_settings();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // register write on an idle block, then read it back
  task automatic write_module_count(input logic [MC_W-1:0] value);
    logic [31:0] word;
    word = $urandom;
    word[MC_W-1:0] = value;
    wait_until_quiet();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_MODULE_COUNT;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    module_count_mirror = value;
    count_writes++;
    // read access straight after the write, select kept high
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[MC_W-1:0] !== value) begin
      $display("%0t: module_count readback expected %0d actual %0d", $time, value,
               prdata[MC_W-1:0]);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // temperatures lean toward the sloped part of the curve
  function automatic logic [TEMP_W-1:0] rand_temp();
    if ($urandom_range(0, 1) == 0) begin
      return TEMP_W'($urandom_range(0, 255));
    end
    return TEMP_W'($urandom_range(10, 80));
  endfunction

  function automatic logic [SRC_W-1:0] rand_source();
    if ($urandom_range(0, 9) < 6) begin
      return SRC_W'($urandom_range(0, 22'h3FFFFF));
    end
    return SRC_W'($urandom_range(0, 31));
  endfunction

  // receiver: random stalls, calm stretches, and long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // result checker: every accepted setting against the oldest owed one
  always @(posedge clk) begin
    fan_setting_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_settings.size() == 0) begin
        $display("%0t: unexpected setting fan %0d duty %0d max %0d last %0d", $time,
                 fan_slot, duty_percent, group_max_temp, last);
        fail_count++;
      end else begin
        want = pending_settings.pop_front();
        settings_checked++;
        if (fan_slot !== want.fan) begin
          $display("%0t: fan_slot expected %0d actual %0d", $time, want.fan, fan_slot);
          fail_count++;
        end
        if (duty_percent !== want.duty) begin
          $display("%0t: duty_percent expected %0d actual %0d", $time, want.duty,
                   duty_percent);
          fail_count++;
        end
        if (group_max_temp !== want.gmax) begin
          $display("%0t: group_max_temp expected %0d actual %0d", $time, want.gmax,
                   group_max_temp);
          fail_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, last);
          fail_count++;
        end
      end
    end
  end

  // field extremes, every kind and the corner cases at the reset count of 8
  task automatic test_directed();
    // tick before anything is attached gives nothing
    send_request(KIND_TICK, '0, '0);
    // ignored kinds, with every payload bit high
    for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++) begin
      send_request(KIND_W'(k), '1, '1);
    end
    // attach twice to the same slot, then tick on a never-written temperature
    send_request(KIND_ATTACH, 22'd3, 8'd200);
    send_request(KIND_ATTACH, 22'd11, 8'd0);
    send_request(KIND_TICK, 22'd5, 8'd0);
    // readings at the curve edges, the largest id lands on the top slot
    send_request(KIND_NORMAL, 22'd0, 8'd255);
    send_request(KIND_NORMAL, 22'h3FFFFF, 8'd45);
    send_request(KIND_URGENT, 22'd5, 8'd20);
    send_request(KIND_URGENT, 22'd6, 8'd70);
    send_request(KIND_URGENT, 22'd1, 8'd21);
    send_request(KIND_URGENT, 22'd2, 8'd69);
    send_request(KIND_TICK, '0, '0);
    // detach an attached slot and one never attached, zero reading
    send_request(KIND_DETACH, 22'd8, 8'd99);
    send_request(KIND_DETACH, 22'd4, 8'd0);
    send_request(KIND_NORMAL, 22'd15, 8'd0);
    send_request(KIND_TICK, '0, '0);
  endtask

  // count of zero acts as one, above the slot count acts as the slot count,
  // and slots above a shrunk count keep their state but drop out of ticks
  task automatic test_count_range();
    write_module_count(4'd0);
    send_request(KIND_NORMAL, rand_source(), 8'd90);
    send_request(KIND_URGENT, rand_source(), 8'd19);
    send_request(KIND_TICK, rand_source(), rand_temp());
    write_module_count(4'd15);
    send_request(KIND_TICK, '0, '0);
    // attached modules remain, but none below the count: tick scans and stays silent
    write_module_count(4'd1);
    send_request(KIND_DETACH, 22'd0, '0);
    send_request(KIND_TICK, '0, '0);
    write_module_count(MC_RESET);
    send_request(KIND_TICK, '0, '0);
  endtask

  // fill every slot, then stall the result side while ticks keep coming
  task automatic test_backpressure();
    write_module_count(MC_RESET);
    for (int i = 0; i < SLOT_CAP; i++) begin
      send_request(KIND_NORMAL, SRC_W'(i), rand_temp());
    end
    hold_req++;
    repeat (8) begin
      send_request(KIND_TICK, rand_source(), rand_temp());
    end
    // sender waits for the whole backlog before going on
    wait_for_settings();
    repeat (4) begin
      send_request(KIND_URGENT, rand_source(), rand_temp());
    end
  endtask

  // random traffic over a spread of module counts, first phase without idling
  task automatic test_random_traffic();
    logic [MC_W-1:0] count_plan [10];
    int pick;
    logic [KIND_W-1:0] k;
    count_plan = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd5, 4'd0, 4'd7, 4'd2, 4'd6, 4'd4};
    for (int p = 0; p < 10; p++) begin
      write_module_count(count_plan[p]);
      calm = (p == 0);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          k = KIND_NORMAL;
        end else if (pick < 40) begin
          k = KIND_DETACH;
        end else if (pick < 50) begin
          k = KIND_ATTACH;
        end else if (pick < 70) begin
          k = KIND_URGENT;
        end else if (pick < 95) begin
          k = KIND_TICK;
        end else begin
          k = KIND_W'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
        end
        send_request(k, rand_source(), rand_temp());
      end
      calm = 1'b0;
    end
  endtask

  // test sequence
  initial begin
    for (int i = 0; i < SLOT_CAP; i++) begin
      fan_attached[i] = 1'b0;
      fan_temp[i] = '0;
    end
    attached_total = 0;
    module_count_mirror = MC_RESET;

    // synchronous reset, held at the start
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_count_range();
    test_backpressure();
    test_random_traffic();

    // drain and let any stray setting show up
    wait_until_quiet();

    $display("run: %0d requests (%0d urgent, %0d ticks), %0d fan settings checked",
             requests_sent, urgent_sent, ticks_sent, settings_checked);
    $display("run: %0d module count writes incl. 0 and 15, one %0d-cycle output hold-off",
             count_writes, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
